FILE: src/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// shared codes for the wav header parser: parse phases, status codes, tags
// ----------------------------------------------------------------------------
package whp_pkg;

	localparam int unsigned PHASE_W = 3;
	localparam int unsigned STATUS_W = 3;

	localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HEAD      = 3'd1;
	localparam logic [PHASE_W-1:0] PH_FMT_SEEK  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_FMT_BODY  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA_SEEK = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DATA_HDR  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_WAVE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FMT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_FMT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_DATA  = 3'd4;

	// four-character codes, first character in the lowest byte
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] POS_RIFF_END = 32'd3;
	localparam logic [31:0] POS_WAVE_END = 32'd11;
	localparam logic [31:0] FIRST_CHUNK  = 32'd12;

	localparam logic [31:0] OFF_ID_END     = 32'd3;
	localparam logic [31:0] OFF_SIZE_END   = 32'd7;
	localparam logic [31:0] OFF_FORMAT_END = 32'd9;
	localparam logic [31:0] OFF_CHAN_END   = 32'd11;
	localparam logic [31:0] OFF_RATE_END   = 32'd15;
	localparam logic [31:0] OFF_BRATE_END  = 32'd19;
	localparam logic [31:0] OFF_ALIGN_END  = 32'd21;
	localparam logic [31:0] OFF_BITS_END   = 32'd23;

	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [15:0] FORMAT_PCM   = 16'd1;

	typedef struct packed {
		logic [31:0] data_size;
		logic [31:0] data_offset;
		logic [31:0] sample_rate;
		logic [15:0] bits_per_sample;
		logic [15:0] channel_count;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

FILE: src/wav_header_parser_core.sv
// ----------------------------------------------------------------------------
// wav_header_parser_core
// walks the riff chunk list of a wav file, one byte per transaction, and
// returns one result per file with status and pcm format details
// each byte is registered in the input stage, and its result in the output register
// throughput: 1 byte per cycle while the output is not stalled, set by the single state update per byte
// while a result waits, the input stage can hold the next byte, but it is not parsed until the result is taken
// reset: asynchronous active low, parser idle until a first byte is seen
// ----------------------------------------------------------------------------
module wav_header_parser_core
	import whp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,       // file_length
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,        // data_byte
	input  logic [0:0]   s_tuser,        // first_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata         // status, channel_count, bits_per_sample,
	                                     // sample_rate, data_offset, data_size, zero pad
);

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        in_first_s1;

	logic [31:0] file_length_q;
	logic [31:0] pos_q;
	logic [31:0] cs_q;
	logic [31:0] ws_q;
	logic [PHASE_W-1:0] phase_q;
	logic        fin_q;
	logic [31:0] fmt_size_q;
	logic [15:0] fmt_code_q;
	logic [15:0] ch_q;
	logic [31:0] rate_q;
	logic [31:0] brate_q;
	logic [15:0] align_q;
	logic [15:0] bits_q;
	logic        rate_ok_q;

	logic        out_valid_q;
	result_t     out_q;

	logic        advance;
	logic        take;

	logic        active;
	logic        in_chunk;
	logic        emit;
	logic [STATUS_W-1:0] st;
	logic [PHASE_W-1:0]  cur_phase;
	logic [31:0] pos_n;
	logic [31:0] cs_n;
	logic [31:0] ws_n;
	logic [PHASE_W-1:0] phase_n;
	logic        fin_n;
	logic [31:0] fmt_size_n;
	logic [15:0] fmt_code_n;
	logic [15:0] ch_n;
	logic [31:0] rate_n;
	logic [31:0] brate_n;
	logic [15:0] align_n;
	logic [15:0] bits_n;
	logic [31:0] off;
	logic [31:0] skip_size;
	logic [32:0] next_start;
	logic        next_ok;
	logic [47:0] rate_prod;
	logic [28:0] align_prod;
	logic        fmt_bad;
	result_t     res;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !in_valid_s1 || advance;
	assign take      = in_valid_s1 && advance;

	assign rate_prod  = rate_q * align_q;
	// bits field >> 3, taken from the byte being shifted in
	assign align_prod = {in_byte_s1, ws_q[31:27]} * ch_q;

	always_comb begin
		active     = 1'b1;
		emit       = 1'b0;
		st         = ST_OK;
		pos_n      = pos_q;
		cs_n       = cs_q;
		ws_n       = ws_q;
		phase_n    = phase_q;
		fin_n      = fin_q;
		fmt_size_n = fmt_size_q;
		fmt_code_n = fmt_code_q;
		ch_n       = ch_q;
		rate_n     = rate_q;
		brate_n    = brate_q;
		align_n    = align_q;
		bits_n     = bits_q;
		if (in_first_s1) begin
			pos_n      = '0;
			cs_n       = '0;
			phase_n    = PH_HEAD;
			fin_n      = 1'b0;
			fmt_size_n = '0;
			fmt_code_n = '0;
			ch_n       = '0;
			rate_n     = '0;
			brate_n    = '0;
			align_n    = '0;
			bits_n     = '0;
		end else if (phase_q == PH_IDLE || fin_q) begin
			active = 1'b0;
		end else begin
			pos_n = pos_q + 32'd1;
		end
		if (active) begin
			ws_n = {in_byte_s1, ws_q[31:8]};
		end
		cur_phase = phase_n;
		in_chunk  = (cur_phase != PH_HEAD) && (pos_n >= cs_n);
		off       = pos_n - cs_n;
		skip_size = (cur_phase == PH_FMT_BODY) ? fmt_size_n : ws_n;
		next_start = {1'b0, cs_n} + {1'b0, skip_size} + 33'd8;
		next_ok    = next_start < {1'b0, file_length_q};
		fmt_bad = (fmt_size_n < FMT_MIN_SIZE) || (fmt_code_n != FORMAT_PCM) || !rate_ok_q
			|| ({13'd0, align_n} != align_prod);
		if (active) begin
			if (cur_phase == PH_HEAD) begin
				if (pos_n == POS_RIFF_END && ws_n != TAG_RIFF) begin
					emit = 1'b1;
					st   = ST_NOT_WAVE;
				end else if (pos_n == POS_WAVE_END) begin
					if (ws_n != TAG_WAVE) begin
						emit = 1'b1;
						st   = ST_NOT_WAVE;
					end else begin
						phase_n = PH_FMT_SEEK;
						cs_n    = FIRST_CHUNK;
					end
				end
			end else if (in_chunk && cur_phase == PH_FMT_SEEK) begin
				if (off == OFF_ID_END && ws_n == TAG_FMT) begin
					phase_n = PH_FMT_BODY;
				end else if (off == OFF_SIZE_END) begin
					if (next_ok) begin
						cs_n = next_start[31:0];
					end else begin
						emit = 1'b1;
						st   = ST_NO_FMT;
					end
				end
			end else if (in_chunk && cur_phase == PH_FMT_BODY) begin
				case (off)
					OFF_SIZE_END:   fmt_size_n = ws_n;
					OFF_FORMAT_END: fmt_code_n = ws_n[31:16];
					OFF_CHAN_END:   ch_n = ws_n[31:16];
					OFF_RATE_END:   rate_n = ws_n;
					OFF_BRATE_END:  brate_n = ws_n;
					OFF_ALIGN_END:  align_n = ws_n[31:16];
					OFF_BITS_END: begin
						bits_n = ws_n[31:16];
						if (fmt_bad) begin
							emit = 1'b1;
							st   = ST_BAD_FMT;
						end else if (!next_ok) begin
							emit = 1'b1;
							st   = ST_NO_DATA;
						end else begin
							cs_n    = next_start[31:0];
							phase_n = PH_DATA_SEEK;
						end
					end
					default: ;
				endcase
			end else if (in_chunk && cur_phase == PH_DATA_SEEK) begin
				if (off == OFF_ID_END && ws_n == TAG_DATA) begin
					phase_n = PH_DATA_HDR;
				end else if (off == OFF_SIZE_END) begin
					if (next_ok) begin
						cs_n = next_start[31:0];
					end else begin
						emit = 1'b1;
						st   = ST_NO_DATA;
					end
				end
			end else if (in_chunk && cur_phase == PH_DATA_HDR) begin
				if (off == OFF_SIZE_END) begin
					emit = 1'b1;
					st   = ST_OK;
				end
			end
			// last byte of the file reached with no result yet
			if (!emit && ({1'b0, pos_n} + 33'd1 >= {1'b0, file_length_q})) begin
				emit = 1'b1;
				case (phase_n)
					PH_HEAD:                  st = ST_NOT_WAVE;
					PH_FMT_SEEK, PH_FMT_BODY: st = ST_NO_FMT;
					default:                  st = ST_NO_DATA;
				endcase
			end
			if (emit) begin
				fin_n = 1'b1;
			end
		end
		res.status          = st;
		res.channel_count   = (st == ST_OK) ? ch_n : 16'd0;
		res.bits_per_sample = (st == ST_OK) ? bits_n : 16'd0;
		res.sample_rate     = (st == ST_OK) ? rate_n : 32'd0;
		res.data_offset     = (st == ST_OK) ? cs_n + 32'd8 : 32'd0;
		res.data_size       = (st == ST_OK) ? ws_n : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			file_length_q <= '0;
			pos_q         <= '0;
			cs_q          <= '0;
			phase_q       <= PH_IDLE;
			fin_q         <= 1'b0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (cfg_valid && cfg_ready) begin
				file_length_q <= cfg_data;
			end
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				pos_q   <= pos_n;
				cs_q    <= cs_n;
				phase_q <= phase_n;
				fin_q   <= fin_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1  <= s_tdata;
			in_first_s1 <= s_tuser[0];
		end
		// product check runs on held values, settled before the last fmt byte
		rate_ok_q <= ({16'd0, brate_q} == rate_prod);
		if (take) begin
			ws_q       <= ws_n;
			fmt_size_q <= fmt_size_n;
			fmt_code_q <= fmt_code_n;
			ch_q       <= ch_n;
			rate_q     <= rate_n;
			brate_q    <= brate_n;
			align_q    <= align_n;
			bits_q     <= bits_n;
		end
		if (take && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q};

endmodule
